// ===== hw/rtl/cpp_pkg.sv =====
// Shared types, constants and helper functions for the camera point projection block.
// Used by cpp_divider, cpp_distort and camera_point_projection_brown; no dependencies.
`default_nettype none
package cpp_pkg;

  localparam int DIV_BITS = 56;
  localparam int REM_W    = 32;

  localparam logic [2:0] CFG_K1 = 3'd0;
  localparam logic [2:0] CFG_K2 = 3'd1;
  localparam logic [2:0] CFG_K3 = 3'd2;
  localparam logic [2:0] CFG_P1 = 3'd3;
  localparam logic [2:0] CFG_P2 = 3'd4;
  localparam logic [2:0] CFG_FX = 3'd5;
  localparam logic [2:0] CFG_FY = 3'd6;
  localparam logic [2:0] CFG_PP = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } cpp_in_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               behind_camera;
    logic               zero_depth;
  } cpp_out_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic behind;
    logic zero;
  } cpp_meta_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic [23:0]        fx;
    logic [23:0]        fy;
    logic [23:0]        cx;
    logic [23:0]        cy;
  } cpp_cfg_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] dq;
  } cpp_div_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return S32_MAX;
    end else if (v < -72'sd2147483648) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_quot(input logic [DIV_BITS-1:0] q,
                                                  input logic neg);
    if (!neg) begin
      if (q > DIV_BITS'(32'h7FFF_FFFF)) begin
        return S32_MAX;
      end
      return q[31:0];
    end
    if (q > DIV_BITS'(32'h8000_0000)) begin
      return S32_MIN;
    end
    return 32'(-q[31:0]);
  endfunction

  function automatic cpp_div_t div_step(input cpp_div_t s, input logic [REM_W-1:0] d);
    logic [REM_W:0] r_in;
    logic [REM_W:0] diff;
    cpp_div_t       o;
    r_in = {s.rem, s.dq[DIV_BITS-1]};
    diff = r_in - {1'b0, d};
    if (!diff[REM_W]) begin
      o.rem = diff[REM_W-1:0];
      o.dq  = {s.dq[DIV_BITS-2:0], 1'b1};
    end else begin
      o.rem = r_in[REM_W-1:0];
      o.dq  = {s.dq[DIV_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cpp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, for two dividends and one divisor.
// Depends on cpp_pkg.
`default_nettype none
module cpp_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_vld,
  input  wire logic [cpp_pkg::DIV_BITS-1:0] dvd_x,
  input  wire logic [cpp_pkg::DIV_BITS-1:0] dvd_y,
  input  wire logic [cpp_pkg::REM_W-1:0]    dvs,
  input  wire cpp_pkg::cpp_meta_t           in_meta,
  output logic                              out_vld,
  output logic [cpp_pkg::DIV_BITS-1:0]      quo_x,
  output logic [cpp_pkg::DIV_BITS-1:0]      quo_y,
  output cpp_pkg::cpp_meta_t                out_meta
);
  import cpp_pkg::*;

  cpp_div_t         sx_r   [DIV_BITS];
  cpp_div_t         sy_r   [DIV_BITS];
  logic [REM_W-1:0] dvs_r  [DIV_BITS];
  cpp_meta_t        meta_r [DIV_BITS];
  logic             vld_r  [DIV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0]   <= div_step('{rem: '0, dq: dvd_x}, dvs);
      sy_r[0]   <= div_step('{rem: '0, dq: dvd_y}, dvs);
      dvs_r[0]  <= dvs;
      meta_r[0] <= in_meta;
      for (int s = 1; s < DIV_BITS; s++) begin
        sx_r[s]   <= div_step(sx_r[s-1], dvs_r[s-1]);
        sy_r[s]   <= div_step(sy_r[s-1], dvs_r[s-1]);
        dvs_r[s]  <= dvs_r[s-1];
        meta_r[s] <= meta_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_BITS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < DIV_BITS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[DIV_BITS-1];
  assign quo_x    = sx_r[DIV_BITS-1].dq;
  assign quo_y    = sy_r[DIV_BITS-1].dq;
  assign out_meta = meta_r[DIV_BITS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/cpp_distort.sv =====
// Distortion and pinhole pipeline: radial and tangential terms, focal scaling, principal point.
// Depends on cpp_pkg.
`default_nettype none
module cpp_distort (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_vld,
  input  wire logic [cpp_pkg::DIV_BITS-1:0] quo_x,
  input  wire logic [cpp_pkg::DIV_BITS-1:0] quo_y,
  input  wire cpp_pkg::cpp_meta_t           in_meta,
  input  wire cpp_pkg::cpp_cfg_t            cfg,
  output logic                              out_vld,
  output cpp_pkg::cpp_out_t                 out_data
);
  import cpp_pkg::*;

  localparam int NST = 11;

  logic      vld_r  [NST];
  cpp_meta_t meta_r [NST];

  logic signed [31:0] xn1_r, yn1_r;
  logic signed [31:0] xn2_r, yn2_r, xx2_r, yy2_r, xy2_r;
  logic signed [31:0] xn3_r, yn3_r, xx3_r, yy3_r, xy3_r, r2_3_r;
  logic signed [31:0] xn4_r, yn4_r, xy4_r, r2_4_r, r4_4_r, tx4_r, ty4_r;
  logic signed [35:0] k1t4_r;
  logic signed [31:0] xn5_r, yn5_r, r6_5_r;
  logic signed [35:0] k1t5_r, k2t5_r, p2tx5_r, p1ty5_r;
  logic signed [36:0] p1xy5_r, p2xy5_r;
  logic signed [31:0] xn6_r, yn6_r;
  logic signed [35:0] k1t6_r, k2t6_r, k3t6_r, p2tx6_r, p1ty6_r;
  logic signed [36:0] p1xy6_r, p2xy6_r;
  logic signed [31:0] xn7_r, yn7_r, poly7_r;
  logic signed [35:0] p2tx7_r, p1ty7_r;
  logic signed [36:0] p1xy7_r, p2xy7_r;
  logic signed [39:0] xp8_r, yp8_r;
  logic signed [35:0] p2tx8_r, p1ty8_r;
  logic signed [36:0] p1xy8_r, p2xy8_r;
  logic signed [31:0] xd9_r, yd9_r;
  logic signed [32:0] pu10_r, pv10_r;
  logic signed [31:0] u11_r, v11_r;

  logic signed [63:0] m_xx, m_yy, m_xy, m_r4, m_r6, m_k1, m_k2, m_k3;
  logic signed [63:0] m_p1xy, m_p2tx, m_p1ty, m_p2xy, m_xp, m_yp;
  logic signed [56:0] m_pu, m_pv;

  always_comb begin
    m_xx   = xn1_r * xn1_r;
    m_yy   = yn1_r * yn1_r;
    m_xy   = xn1_r * yn1_r;
    m_r4   = r2_3_r * r2_3_r;
    m_k1   = cfg.k1 * r2_3_r;
    m_r6   = r4_4_r * r2_4_r;
    m_k2   = cfg.k2 * r4_4_r;
    m_p1xy = cfg.p1 * xy4_r;
    m_p2xy = cfg.p2 * xy4_r;
    m_p2tx = cfg.p2 * tx4_r;
    m_p1ty = cfg.p1 * ty4_r;
    m_k3   = cfg.k3 * r6_5_r;
    m_xp   = xn7_r * poly7_r;
    m_yp   = yn7_r * poly7_r;
    m_pu   = $signed({1'b0, cfg.fx}) * xd9_r;
    m_pv   = $signed({1'b0, cfg.fy}) * yd9_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= in_meta;
      for (int s = 1; s < NST; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
      xn1_r   <= sat_quot(quo_x, in_meta.neg_x);
      yn1_r   <= sat_quot(quo_y, in_meta.neg_y);
      xn2_r   <= xn1_r;
      yn2_r   <= yn1_r;
      xx2_r   <= sat32(72'(m_xx >>> 24));
      yy2_r   <= sat32(72'(m_yy >>> 24));
      xy2_r   <= sat32(72'(m_xy >>> 24));
      xn3_r   <= xn2_r;
      yn3_r   <= yn2_r;
      xx3_r   <= xx2_r;
      yy3_r   <= yy2_r;
      xy3_r   <= xy2_r;
      r2_3_r  <= sat32(72'(xx2_r) + 72'(yy2_r));
      xn4_r   <= xn3_r;
      yn4_r   <= yn3_r;
      xy4_r   <= xy3_r;
      r2_4_r  <= r2_3_r;
      r4_4_r  <= sat32(72'(m_r4 >>> 24));
      k1t4_r  <= m_k1[63:28];
      tx4_r   <= sat32(72'(r2_3_r) + 72'(xx3_r) + 72'(xx3_r));
      ty4_r   <= sat32(72'(r2_3_r) + 72'(yy3_r) + 72'(yy3_r));
      xn5_r   <= xn4_r;
      yn5_r   <= yn4_r;
      r6_5_r  <= sat32(72'(m_r6 >>> 24));
      k1t5_r  <= k1t4_r;
      k2t5_r  <= m_k2[63:28];
      p1xy5_r <= m_p1xy[63:27];
      p2xy5_r <= m_p2xy[63:27];
      p2tx5_r <= m_p2tx[63:28];
      p1ty5_r <= m_p1ty[63:28];
      xn6_r   <= xn5_r;
      yn6_r   <= yn5_r;
      k1t6_r  <= k1t5_r;
      k2t6_r  <= k2t5_r;
      k3t6_r  <= m_k3[63:28];
      p1xy6_r <= p1xy5_r;
      p2xy6_r <= p2xy5_r;
      p2tx6_r <= p2tx5_r;
      p1ty6_r <= p1ty5_r;
      xn7_r   <= xn6_r;
      yn7_r   <= yn6_r;
      poly7_r <= sat32(72'sd16777216 + 72'(k1t6_r) + 72'(k2t6_r) + 72'(k3t6_r));
      p1xy7_r <= p1xy6_r;
      p2xy7_r <= p2xy6_r;
      p2tx7_r <= p2tx6_r;
      p1ty7_r <= p1ty6_r;
      xp8_r   <= m_xp[63:24];
      yp8_r   <= m_yp[63:24];
      p1xy8_r <= p1xy7_r;
      p2xy8_r <= p2xy7_r;
      p2tx8_r <= p2tx7_r;
      p1ty8_r <= p1ty7_r;
      xd9_r   <= sat32(72'(xp8_r) + 72'(p1xy8_r) + 72'(p2tx8_r));
      yd9_r   <= sat32(72'(yp8_r) + 72'(p1ty8_r) + 72'(p2xy8_r));
      pu10_r  <= m_pu[56:24];
      pv10_r  <= m_pv[56:24];
      u11_r   <= sat32(72'(pu10_r) + 72'($signed({1'b0, cfg.cx})));
      v11_r   <= sat32(72'(pv10_r) + 72'($signed({1'b0, cfg.cy})));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_comb begin
    out_data.behind_camera = meta_r[NST-1].behind;
    out_data.zero_depth    = meta_r[NST-1].zero;
    out_data.pixel_u       = meta_r[NST-1].zero ? '0 : u11_r;
    out_data.pixel_v       = meta_r[NST-1].zero ? '0 : v11_r;
  end

  assign out_vld = vld_r[NST-1];

endmodule
`default_nettype wire

// ===== hw/rtl/camera_point_projection_brown.sv =====
// Top level of the Brown-Conrady camera point projection pipeline with its register file.
// Depends on cpp_pkg, cpp_divider and cpp_distort.
//
// One camera-frame point (Q16.16) is taken per clock unless the output is held off, and is
// projected to a saturated Q22.10 pixel; every point gives one result transaction. Each point
// passes through the 56-stage pipelined divider (one quotient bit per stage, x/z and y/z side
// by side) and then eleven stages of distortion and focal arithmetic. When the output is
// held off, the whole pipeline holds in place; configuration writes take effect at once and
// belong to times when no transaction is in flight.
`default_nettype none
module camera_point_projection_brown (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cpp_pkg::cpp_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cpp_pkg::cpp_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [47:0]       cfg_wdata
);
  import cpp_pkg::*;

  cpp_cfg_t            cfg_r;
  logic                en;
  logic                acc;
  logic [REM_W-1:0]    ax, ay, az;
  logic [DIV_BITS-1:0] dvd_x, dvd_y;
  cpp_meta_t           meta_in;
  logic                dv_vld;
  logic [DIV_BITS-1:0] quo_x, quo_y;
  cpp_meta_t           dv_meta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k1 <= '0;
      cfg_r.k2 <= '0;
      cfg_r.k3 <= '0;
      cfg_r.p1 <= '0;
      cfg_r.p2 <= '0;
      cfg_r.fx <= 24'd1024;
      cfg_r.fy <= 24'd1024;
      cfg_r.cx <= '0;
      cfg_r.cy <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_K1: cfg_r.k1 <= cfg_wdata[31:0];
        CFG_K2: cfg_r.k2 <= cfg_wdata[31:0];
        CFG_K3: cfg_r.k3 <= cfg_wdata[31:0];
        CFG_P1: cfg_r.p1 <= cfg_wdata[31:0];
        CFG_P2: cfg_r.p2 <= cfg_wdata[31:0];
        CFG_FX: cfg_r.fx <= cfg_wdata[23:0];
        CFG_FY: cfg_r.fy <= cfg_wdata[23:0];
        CFG_PP: begin
          cfg_r.cx <= cfg_wdata[23:0];
          cfg_r.cy <= cfg_wdata[47:24];
        end
        default: begin
        end
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;

  always_comb begin
    ax = in_data.point_x[31] ? 32'(-in_data.point_x) : in_data.point_x;
    ay = in_data.point_y[31] ? 32'(-in_data.point_y) : in_data.point_y;
    az = in_data.point_z[31] ? 32'(-in_data.point_z) : in_data.point_z;
    dvd_x = {ax, 24'd0};
    dvd_y = {ay, 24'd0};
    meta_in.neg_x  = in_data.point_x[31] ^ in_data.point_z[31];
    meta_in.neg_y  = in_data.point_y[31] ^ in_data.point_z[31];
    meta_in.behind = in_data.point_z[31];
    meta_in.zero   = (in_data.point_z == '0);
  end

  cpp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (acc),
    .dvd_x    (dvd_x),
    .dvd_y    (dvd_y),
    .dvs      (az),
    .in_meta  (meta_in),
    .out_vld  (dv_vld),
    .quo_x    (quo_x),
    .quo_y    (quo_y),
    .out_meta (dv_meta)
  );

  cpp_distort u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_vld),
    .quo_x    (quo_x),
    .quo_y    (quo_y),
    .in_meta  (dv_meta),
    .cfg      (cfg_r),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/camera_point_projection_brown_tb.sv =====
// Self-checking testbench for camera_point_projection_brown: drives camera-frame points
// through valid/ready with random idling and compares each pixel result with a local model.
// Depends on cpp_pkg and the camera_point_projection_brown RTL.
`timescale 1ns / 1ps
module camera_point_projection_brown_tb;
  import cpp_pkg::*;

  localparam int LATENCY = 67;
  localparam int N_RANDOM = 1130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cpp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cpp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_K1;
  logic [47:0] cfg_wdata = '0;

  camera_point_projection_brown u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  longint m_k1, m_k2, m_k3, m_p1, m_p2, m_fx, m_fy, m_cx, m_cy;
  cpp_out_t pixel_queue[$];
  int errors = 0;
  bit rx_idle_on = 1'b1;
  bit long_hold = 1'b0;
  bit tx_idle_on = 1'b1;

  typedef struct {
    cpp_in_t pt;
    bit has_exp;
    cpp_out_t exp_px;
  } point_row_t;
  point_row_t point_table[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32(floor_shift(a * b, 24));
  endfunction

  function automatic cpp_out_t project_point(cpp_in_t p);
    cpp_out_t r;
    longint x, y, z, xn, yn, xx, yy, xy, r2, r4, r6, poly, xd, yd;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    z = longint'(p.point_z);
    r = '0;
    if (z == 0) begin
      r.zero_depth = 1'b1;
      return r;
    end
    r.behind_camera = z < 0;
    xn = clamp32((x * 64'sd16777216) / z);
    yn = clamp32((y * 64'sd16777216) / z);
    xx = qmul(xn, xn);
    yy = qmul(yn, yn);
    xy = qmul(xn, yn);
    r2 = clamp32(xx + yy);
    r4 = qmul(r2, r2);
    r6 = qmul(r4, r2);
    poly = clamp32(64'sd16777216 + floor_shift(m_k1 * r2, 28)
                   + floor_shift(m_k2 * r4, 28) + floor_shift(m_k3 * r6, 28));
    xd = clamp32(floor_shift(xn * poly, 24) + floor_shift(m_p1 * xy, 27)
                 + floor_shift(m_p2 * clamp32(r2 + 2 * xx), 28));
    yd = clamp32(floor_shift(yn * poly, 24) + floor_shift(m_p1 * clamp32(r2 + 2 * yy), 28)
                 + floor_shift(m_p2 * xy, 27));
    r.pixel_u = 32'(clamp32(floor_shift(m_fx * xd, 24) + m_cx));
    r.pixel_v = 32'(clamp32(floor_shift(m_fy * yd, 24) + m_cy));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_K1: m_k1 = longint'($signed(val[31:0]));
      CFG_K2: m_k2 = longint'($signed(val[31:0]));
      CFG_K3: m_k3 = longint'($signed(val[31:0]));
      CFG_P1: m_p1 = longint'($signed(val[31:0]));
      CFG_P2: m_p2 = longint'($signed(val[31:0]));
      CFG_FX: m_fx = longint'(val[23:0]);
      CFG_FY: m_fy = longint'(val[23:0]);
      default: begin
        m_cx = longint'(val[23:0]);
        m_cy = longint'(val[47:24]);
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The valid line stays high after an accepted transaction; the next transaction, an idle
  // gap or a drain takes it over in the same time step.
  task automatic send_point(cpp_in_t p, bit has_exp, cpp_out_t exp_px);
    int gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    pixel_queue.push_back(has_exp ? exp_px : project_point(p));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'($signed(-$urandom_range(1, 1 << 22)));
      3: return $urandom_range(1, 64);
      default: return $urandom_range(1 << 15, 1 << 23);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic random_config();
    write_reg(CFG_K1, 48'(rand_coef()));
    write_reg(CFG_K2, 48'(rand_coef()));
    write_reg(CFG_K3, 48'(rand_coef()));
    write_reg(CFG_P1, 48'(rand_coef()));
    write_reg(CFG_P2, 48'(rand_coef()));
    write_reg(CFG_FX, 48'($urandom_range(0, 1 << 24) & 24'hFFFFFF));
    write_reg(CFG_FY, 48'($urandom_range(0, 1 << 24) & 24'hFFFFFF));
    write_reg(CFG_PP, {24'($urandom()), 24'($urandom())});
  endtask

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit has_exp,
                         cpp_out_t e);
    point_row_t row;
    row.pt = '{point_x: x, point_y: y, point_z: z};
    row.has_exp = has_exp;
    row.exp_px = e;
    point_table.push_back(row);
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        cpp_out_t e;
        e = pixel_queue.pop_front();
        if (out_data.pixel_u !== e.pixel_u)
          report_mismatch("pixel_u", out_data.pixel_u, e.pixel_u);
        if (out_data.pixel_v !== e.pixel_v)
          report_mismatch("pixel_v", out_data.pixel_v, e.pixel_v);
        if (out_data.behind_camera !== e.behind_camera)
          report_mismatch("behind_camera", out_data.behind_camera, e.behind_camera);
        if (out_data.zero_depth !== e.zero_depth)
          report_mismatch("zero_depth", out_data.zero_depth, e.zero_depth);
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("camera_point_projection_brown_tb: errors");
    $finish;
  end

  initial begin
    cpp_out_t e;
    m_k1 = 0; m_k2 = 0; m_k3 = 0; m_p1 = 0; m_p2 = 0;
    m_fx = 1024; m_fy = 1024; m_cx = 0; m_cy = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    e = '0;
    e.zero_depth = 1'b1;
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1, e);
    add_row(32'h0, 32'h0, 32'd0, 1'b1, e);
    e = '0;
    add_row(32'h0, 32'h0, 32'h0001_0000, 1'b1, e);
    e.pixel_u = 32'sd512;
    e.pixel_v = -32'sd512;
    add_row(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 1'b1, e);
    add_row(32'h0, 32'h0, 32'hFFFF_0000, 1'b0, e);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0, e);
    add_row(32'h8000_0000, 32'h8000_0000, 32'd1, 1'b0, e);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, e);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, e);
    add_row(32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF, 1'b0, e);
    add_row(32'h0003_0000, 32'hFFFE_0000, 32'h0004_0000, 1'b0, e);
    foreach (point_table[i])
      send_point(point_table[i].pt, point_table[i].has_exp, point_table[i].exp_px);
    drain();

    write_reg(CFG_K1, 48'h7FFF_FFFF);
    write_reg(CFG_K2, 48'h8000_0000);
    write_reg(CFG_K3, 48'h7FFF_FFFF);
    write_reg(CFG_P1, 48'h8000_0000);
    write_reg(CFG_P2, 48'h7FFF_FFFF);
    write_reg(CFG_FX, 48'hFF_FFFF);
    write_reg(CFG_FY, 48'h0);
    write_reg(CFG_PP, 48'hFFFF_FFFF_FFFF);
    foreach (point_table[i]) send_point(point_table[i].pt, 1'b0, e);
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      cpp_in_t p;
      if (n % 150 == 0) begin
        drain();
        random_config();
      end
      if (n == 300) long_hold = 1'b1;
      if (n == 600) drain();
      if (n == N_RANDOM - 150) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      p.point_x = rand_coord();
      p.point_y = rand_coord();
      p.point_z = rand_depth();
      send_point(p, 1'b0, e);
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("camera_point_projection_brown_tb: clean");
    end else begin
      $display("camera_point_projection_brown_tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/cpp_pkg.sv
hw/rtl/cpp_divider.sv
hw/rtl/cpp_distort.sv
hw/rtl/camera_point_projection_brown.sv
tb/sv/camera_point_projection_brown_tb.sv
